@@ sv/bxt_pkg.sv @@
// Package for the bounded XML tokenizer.
// Holds the transfer payload types, token kind and error codes, and byte constants.
// No dependencies.
package bxt_pkg;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_SPECIAL = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_OPEN_COMMENT = 3'd1;
    localparam logic [2:0] ERR_OPEN_PI      = 3'd2;
    localparam logic [2:0] ERR_DECL         = 3'd3;
    localparam logic [2:0] ERR_OPEN_MARKUP  = 3'd4;
    localparam logic [2:0] ERR_WINDOW       = 3'd5;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam int          WINDOW_BITS  = 16;
    localparam logic [15:0] WINDOW_RESET = 16'd4096;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_bxt_in;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [15:0] token_length;
        logic [2:0]  error_code;
    } t_bxt_out;

endpackage

@@ sv/bxt_core.sv @@
// Tokenizer core: per-byte state update and the result register.
// Depends on bxt_pkg.
module bxt_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  bxt_pkg::t_bxt_in           i_item,
    input  logic [bxt_pkg::WINDOW_BITS-1:0] i_max_window,
    input  logic                       i_out_ready,
    output logic                       o_take,
    output logic                       o_out_valid,
    output bxt_pkg::t_bxt_out          o_out
);
    import bxt_pkg::*;

    localparam int CW = (LENGTH_BITS > WINDOW_BITS) ? LENGTH_BITS : WINDOW_BITS;
    localparam logic [CW-1:0] LEN_MAX = CW'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_DOUBLE = 2'd1;
    localparam logic [1:0] Q_SINGLE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TEXT, PH_LT, PH_BANG, PH_BANGDASH, PH_COMMENT, PH_PI, PH_TAG
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [1:0]             r_quote, n_quote;
    logic [1:0]             r_match, n_match;
    logic                   r_err, n_err;
    logic                   r_out_valid;
    t_bxt_out               r_out;

    logic                   emit;
    logic [1:0]             e_kind;
    logic [LENGTH_BITS-1:0] e_len;
    logic [2:0]             e_code;
    logic [CW-1:0]          len_ext, win_ext, limit, e_len_ext;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [7:0]             b;

    assign o_take      = i_step && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign b         = i_item.data_byte;
    assign len_ext   = CW'(r_len);
    assign win_ext   = CW'(i_max_window);
    assign limit     = (win_ext < LEN_MAX) ? win_ext : LEN_MAX;
    assign len_inc   = r_len + LENGTH_BITS'(1);
    assign e_len_ext = CW'(e_len);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_quote = r_quote;
        n_match = r_match;
        n_err   = r_err;
        emit    = 1'b0;
        e_kind  = KIND_TEXT;
        e_len   = '0;
        e_code  = ERR_NONE;
        if (i_item.opcode == OP_EOS) begin
            if (!r_err) begin
                unique case (r_phase)
                    PH_TEXT: begin
                        emit  = 1'b1;
                        e_len = r_len;
                    end
                    PH_LT, PH_TAG: begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_OPEN_MARKUP;
                    end
                    PH_BANG, PH_BANGDASH: begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_DECL;
                    end
                    PH_COMMENT: begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_OPEN_COMMENT;
                    end
                    PH_PI: begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_OPEN_PI;
                    end
                    PH_IDLE: ;
                endcase
            end
            n_phase = PH_IDLE;
            n_len   = '0;
            n_quote = Q_NONE;
            n_match = 2'd0;
            n_err   = 1'b0;
        end else if (!r_err) begin
            if (len_ext >= limit) begin
                emit   = 1'b1;
                e_kind = KIND_ERROR;
                e_code = ERR_WINDOW;
                n_err  = 1'b1;
            end else begin
                n_len = len_inc;
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = (b == CH_LT) ? PH_LT : PH_TEXT;
                    end
                    PH_TEXT: begin
                        if (b == CH_LT) begin
                            emit    = 1'b1;
                            e_len   = r_len;
                            n_len   = LENGTH_BITS'(1);
                            n_phase = PH_LT;
                        end
                    end
                    PH_LT: begin
                        priority if (b == CH_BANG) begin
                            n_phase = PH_BANG;
                        end else if (b == CH_QMARK) begin
                            n_phase = PH_PI;
                            n_match = 2'd0;
                        end else if (b == CH_GT) begin
                            emit    = 1'b1;
                            e_kind  = KIND_TAG;
                            e_len   = len_inc;
                            n_phase = PH_IDLE;
                            n_len   = '0;
                            n_quote = Q_NONE;
                            n_match = 2'd0;
                        end else begin
                            n_phase = PH_TAG;
                            n_quote = (b == CH_DQUOTE) ? Q_DOUBLE :
                                      (b == CH_SQUOTE) ? Q_SINGLE : Q_NONE;
                        end
                    end
                    PH_BANG, PH_BANGDASH: begin
                        if (b != CH_DASH) begin
                            emit   = 1'b1;
                            e_kind = KIND_ERROR;
                            e_code = ERR_DECL;
                            n_err  = 1'b1;
                        end else if (r_phase == PH_BANG) begin
                            n_phase = PH_BANGDASH;
                        end else begin
                            n_phase = PH_COMMENT;
                            n_match = 2'd0;
                        end
                    end
                    PH_COMMENT: begin
                        priority if (b == CH_DASH) begin
                            if (r_match < 2'd2) n_match = r_match + 2'd1;
                        end else if (b == CH_GT && r_match == 2'd2) begin
                            emit    = 1'b1;
                            e_kind  = KIND_SPECIAL;
                            e_len   = len_inc;
                            n_phase = PH_IDLE;
                            n_len   = '0;
                            n_quote = Q_NONE;
                            n_match = 2'd0;
                        end else begin
                            n_match = 2'd0;
                        end
                    end
                    PH_PI: begin
                        priority if (b == CH_QMARK) begin
                            n_match = 2'd1;
                        end else if (b == CH_GT && r_match == 2'd1) begin
                            emit    = 1'b1;
                            e_kind  = KIND_SPECIAL;
                            e_len   = len_inc;
                            n_phase = PH_IDLE;
                            n_len   = '0;
                            n_quote = Q_NONE;
                            n_match = 2'd0;
                        end else begin
                            n_match = 2'd0;
                        end
                    end
                    PH_TAG: begin
                        priority if (r_quote == Q_DOUBLE) begin
                            if (b == CH_DQUOTE) n_quote = Q_NONE;
                        end else if (r_quote == Q_SINGLE) begin
                            if (b == CH_SQUOTE) n_quote = Q_NONE;
                        end else if (b == CH_DQUOTE) begin
                            n_quote = Q_DOUBLE;
                        end else if (b == CH_SQUOTE) begin
                            n_quote = Q_SINGLE;
                        end else if (b == CH_GT) begin
                            emit    = 1'b1;
                            e_kind  = KIND_TAG;
                            e_len   = len_inc;
                            n_phase = PH_IDLE;
                            n_len   = '0;
                            n_quote = Q_NONE;
                            n_match = 2'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= '0;
            r_quote     <= Q_NONE;
            r_match     <= 2'd0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_quote     <= n_quote;
            r_match     <= n_match;
            r_err       <= n_err;
            r_out_valid <= emit;
            if (emit) begin
                r_out.token_kind   <= e_kind;
                r_out.token_length <= e_len_ext[15:0];
                r_out.error_code   <= e_code;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

@@ sv/bounded_xml_tokenizer.sv @@
// Bounded XML tokenizer top level: input register, window register, core.
// A result passes through the input register, then the core's result register.
// Throughput: one item per cycle unless the output stalls; the per-byte update
// is one state step.
// Reset (synchronous, active low) clears the token state, error flag and
// both valid flags, and sets max_window to 4096. Depends on bxt_pkg, bxt_core.
module bounded_xml_tokenizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bxt_pkg::t_bxt_in           i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bxt_pkg::t_bxt_out          o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bxt_pkg::WINDOW_BITS-1:0] i_cfg_data
);
    import bxt_pkg::*;

    logic                   r_in_valid;
    t_bxt_in                r_in;
    logic [WINDOW_BITS-1:0] r_max_window;
    logic                   take;

    assign o_in_ready  = !r_in_valid || take;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_max_window <= WINDOW_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) r_max_window <= i_cfg_data;
        end
    end

    bxt_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_in_valid),
        .i_item       (r_in),
        .i_max_window (r_max_window),
        .i_out_ready  (i_out_ready),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

endmodule

@@ sv/bxt_checker.sv @@
// Port-level checker for the bounded XML tokenizer, bound to the top level.
// Depends on bxt_pkg and bounded_xml_tokenizer.
module bxt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input bxt_pkg::t_bxt_out o_out
);
    import bxt_pkg::*;

    a_err_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.token_kind == KIND_ERROR |-> o_out.token_length == 16'd0)
        else $error("error transfer with nonzero length");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.token_kind != KIND_ERROR |-> o_out.error_code == ERR_NONE)
        else $error("error code on non-error transfer");

    a_err_code_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.token_kind == KIND_ERROR |->
            (o_out.error_code != ERR_NONE && o_out.error_code <= ERR_WINDOW))
        else $error("bad error code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind bounded_xml_tokenizer bxt_checker u_bxt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
